// ===== src/bia_pkg.sv =====
package bia_pkg;

	localparam int MAX_BITS  = 1024;
	localparam int WORD_BITS = 32;
	localparam int NUM_WORDS = MAX_BITS / WORD_BITS;
	localparam int ADDR_W    = $clog2(NUM_WORDS);
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int INDEX_W   = 10;
	localparam int COUNT_W   = 11;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_BITS);

	typedef logic [WORD_BITS-1:0] word_t;

	// bits of word w that lie below the index limit
	function automatic word_t word_mask(logic [ADDR_W-1:0] w, logic [COUNT_W-1:0] limit);
		logic [COUNT_W-1:0] base;
		logic [COUNT_W-1:0] n;
		word_t m;
		base = COUNT_W'(w) << BIT_W;
		n = limit - base;
		if (limit <= base) begin
			m = '0;
		end else if (n >= COUNT_W'(WORD_BITS)) begin
			m = '1;
		end else begin
			m = (word_t'(1) << n[BIT_W-1:0]) - word_t'(1);
		end
		return m;
	endfunction

	// position of the lowest set bit, byte first then bit within the byte
	function automatic logic [BIT_W-1:0] first_set(word_t v);
		logic [WORD_BITS/8-1:0] nz;
		logic [BIT_W-4:0] sel;
		logic [7:0] bv;
		logic [2:0] pos;
		for (int i = 0; i < WORD_BITS/8; i++) begin
			nz[i] = |v[i*8 +: 8];
		end
		sel = '0;
		for (int i = WORD_BITS/8 - 1; i >= 0; i--) begin
			if (nz[i]) begin
				sel = (BIT_W-3)'(i);
			end
		end
		bv = v[sel*8 +: 8];
		pos = '0;
		for (int i = 7; i >= 0; i--) begin
			if (bv[i]) begin
				pos = 3'(i);
			end
		end
		return {sel, pos};
	endfunction

endpackage

// ===== src/bia_ram.sv =====
module bia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/bitmap_index_allocator.sv =====
// bitmap index allocator: hands out indices 0 .. num_bits-1 from a bitmap of
// 32 words of 32 bits held in a one-port-read, one-port-write ram. cmd 0
// allocates the lowest free index of the first word that has one, scanning
// the words cyclically from the word of the last successful allocation; cmd 1
// frees an index, cmd 2 tests one. every item gives one result with status,
// granted index, test bit and the used count after the item. items are taken
// one at a time: an allocate scans the words from the word of the last grant,
// one word per cycle, and is full if no word has a free bit below the limit or
// if the used count is already at the limit. a free or test does a ram read,
// then a read-modify-write; an out-of-range index or unknown cmd goes straight
// to its result. the next item is taken while the result still waits in the
// output register. the bitmap is empty right after reset: a valid flag per
// word makes a word never written since reset read as zero, so no clearing
// pass is needed. the user must write num_bits over the cfg channel only while
// the block is idle; the block does not enforce it. values above 1024 act as
// 1024 and zero makes every allocate full and every index out of range.
module bitmap_index_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write channel: num_bits
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bia_pkg::COUNT_W-1:0]       cfg_data,
	// input items
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [bia_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [9:0] bit_index, rest zero
	input  logic [bia_pkg::CMD_W-1:0]         s_axis_tuser,  // [1:0] cmd
	// result items
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [bia_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [9:0] alloc_index, [10] is_set,
	                                                         // [21:11] used_count, rest zero
	output logic [bia_pkg::STATUS_W-1:0]      m_axis_tuser   // [1:0] status
);

	import bia_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_ALLOC,
		S_RMW,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [COUNT_W-1:0] num_bits_q;
	logic [COUNT_W-1:0] limit;

	// item and scan state
	logic [CMD_W-1:0]   cmd_q;
	logic [INDEX_W-1:0] idx_q;
	logic [ADDR_W-1:0]  cur_q;       // word being examined by the scan
	logic [ADDR_W-1:0]  cnt_q;       // words examined so far
	logic [ADDR_W-1:0]  last_word_q;
	logic [COUNT_W-1:0] used_q;
	word_t              word_q;      // word found with a free bit
	word_t              avail_q;     // its free bits below the limit

	// word valid flags: a word not written since reset reads as all free
	logic [NUM_WORDS-1:0] valid_q;
	logic                 rvalid_s1;

	// pending result
	logic [STATUS_W-1:0] res_status_q;
	logic [INDEX_W-1:0]  res_index_q;
	logic                res_set_q;

	// output register
	logic                m_valid_q;
	logic [STATUS_W-1:0] m_status_q;
	logic [INDEX_W-1:0]  m_index_q;
	logic                m_set_q;
	logic [COUNT_W-1:0]  m_count_q;
	logic                out_load;

	// ram ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	word_t             ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	word_t             ram_rdata;

	// datapath
	word_t             rd_word;
	word_t             scan_avail;
	logic [BIT_W-1:0]  grant_bit;
	word_t             free_onehot;
	word_t             idx_onehot;
	logic              idx_bit;
	logic              in_accept;
	logic [INDEX_W-1:0] in_idx;
	logic [CMD_W-1:0]  in_cmd;
	logic              in_range;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign in_idx    = s_axis_tdata[INDEX_W-1:0];
	assign in_cmd    = s_axis_tuser;

	// effective index limit, clamped to the store size
	assign limit    = (num_bits_q > MAX_COUNT) ? MAX_COUNT : num_bits_q;
	assign in_range = COUNT_W'(in_idx) < limit;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);

	// result moves to the output register once that register is free
	assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

	assign rd_word     = rvalid_s1 ? ram_rdata : '0;
	assign scan_avail  = ~rd_word & word_mask(cur_q, limit);
	assign grant_bit   = first_set(avail_q);
	assign free_onehot = word_t'(1) << grant_bit;
	assign idx_onehot  = word_t'(1) << idx_q[BIT_W-1:0];
	assign idx_bit     = |(rd_word & idx_onehot);

	// read address: first word at accept, then one word ahead during the scan
	always_comb begin
		ram_raddr = cur_q;
		if (state_q == S_IDLE) begin
			ram_raddr = (in_cmd == CMD_ALLOC) ? last_word_q : in_idx[INDEX_W-1 -: ADDR_W];
		end else if (state_q == S_SCAN) begin
			ram_raddr = cur_q + ADDR_W'(1);
		end
	end

	// write back: set the granted bit, or clear a freed bit that was set
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[INDEX_W-1 -: ADDR_W];
		ram_wdata = rd_word & ~idx_onehot;
		if (state_q == S_ALLOC) begin
			ram_we    = 1'b1;
			ram_waddr = cur_q;
			ram_wdata = word_q | free_onehot;
		end else if (state_q == S_RMW && cmd_q == CMD_FREE && idx_bit) begin
			ram_we = 1'b1;
		end
	end

	bia_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (NUM_WORDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			num_bits_q   <= MAX_COUNT;
			cmd_q        <= CMD_ALLOC;
			idx_q        <= '0;
			cur_q        <= '0;
			cnt_q        <= '0;
			last_word_q  <= '0;
			used_q       <= '0;
			word_q       <= '0;
			avail_q      <= '0;
			valid_q      <= '0;
			rvalid_s1    <= 1'b0;
			res_status_q <= ST_OK;
			res_index_q  <= '0;
			res_set_q    <= 1'b0;
			m_valid_q    <= 1'b0;
			m_status_q   <= ST_OK;
			m_index_q    <= '0;
			m_set_q      <= 1'b0;
			m_count_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				num_bits_q <= cfg_data;
			end

			rvalid_s1 <= valid_q[ram_raddr];
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end

			if (out_load) begin
				m_valid_q  <= 1'b1;
				m_status_q <= res_status_q;
				m_index_q  <= res_index_q;
				m_set_q    <= res_set_q;
				m_count_q  <= used_q;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						cmd_q       <= in_cmd;
						idx_q       <= in_idx;
						cur_q       <= last_word_q;
						cnt_q       <= '0;
						res_index_q <= '0;
						res_set_q   <= 1'b0;
						case (in_cmd) inside
							CMD_ALLOC: begin
								if (used_q >= limit) begin
									res_status_q <= ST_FULL;
									state_q      <= S_OUT;
								end else begin
									res_status_q <= ST_OK;
									state_q      <= S_SCAN;
								end
							end
							CMD_FREE, CMD_TEST: begin
								if (in_range) begin
									res_status_q <= ST_OK;
									state_q      <= S_RMW;
								end else begin
									res_status_q <= ST_RANGE;
									state_q      <= S_OUT;
								end
							end
							default: begin
								res_status_q <= ST_OK;
								state_q      <= S_OUT;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (|scan_avail) begin
						word_q  <= rd_word;
						avail_q <= scan_avail;
						state_q <= S_ALLOC;
					end else if (cnt_q == ADDR_W'(NUM_WORDS - 1)) begin
						// no free index below the limit in any word
						res_status_q <= ST_FULL;
						state_q      <= S_OUT;
					end else begin
						cur_q <= cur_q + ADDR_W'(1);
						cnt_q <= cnt_q + ADDR_W'(1);
					end
				end
				S_ALLOC: begin
					last_word_q <= cur_q;
					used_q      <= used_q + COUNT_W'(1);
					res_index_q <= {cur_q, grant_bit};
					state_q     <= S_OUT;
				end
				S_RMW: begin
					if (cmd_q == CMD_FREE) begin
						if (idx_bit && used_q != '0) begin
							used_q <= used_q - COUNT_W'(1);
						end
					end else begin
						res_set_q <= idx_bit;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tdata  = OUT_DATA_W'({m_count_q, m_set_q, m_index_q});

endmodule

// ===== src/bia_checker.sv =====
module bia_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [bia_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic [bia_pkg::STATUS_W-1:0]      m_axis_tuser
);

	import bia_pkg::*;

	logic [INDEX_W-1:0] chk_index;
	logic               chk_set;
	logic [COUNT_W-1:0] chk_count;

	assign chk_index = m_axis_tdata[INDEX_W-1:0];
	assign chk_set   = m_axis_tdata[INDEX_W];
	assign chk_count = m_axis_tdata[INDEX_W+1 +: COUNT_W];

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// used count never exceeds the store size
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> chk_count <= MAX_COUNT)
		else $error("used count above store size");

	// a full or out-of-range result grants nothing and reports no set bit
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_FULL || m_axis_tuser == ST_RANGE) |->
			chk_index == '0 && !chk_set)
		else $error("rejected item carries a grant or test bit");

	// a test bit and a granted index never come together
	a_set_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && chk_set |-> chk_index == '0 && m_axis_tuser == ST_OK)
		else $error("test result mixed with a grant");

endmodule

bind bitmap_index_allocator bia_checker u_bia_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== test/bia_result_checker.sv =====
module bia_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [bia_pkg::COUNT_W-1:0]    cfg_data,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [bia_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [9:0] bit_index, rest zero
	input  logic [bia_pkg::CMD_W-1:0]      s_axis_tuser,   // [1:0] cmd
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [bia_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [9:0] alloc_index, [10] is_set,
	                                                       // [21:11] used_count, rest zero
	input  logic [bia_pkg::STATUS_W-1:0]   m_axis_tuser,   // [1:0] status
	output int                             failures,
	output int                             outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import bia_pkg::*;

	localparam int PAD_LO = INDEX_W + 1 + COUNT_W;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  alloc_index;
		logic                is_set;
		logic [COUNT_W-1:0]  used_count;
	} response_t;

	// shadow copy of the allocator
	word_t              shadow_words [NUM_WORDS];
	logic [ADDR_W-1:0]  shadow_last;
	logic [COUNT_W-1:0] shadow_used;
	logic [COUNT_W-1:0] shadow_num_bits;

	response_t expected_responses [$];
	int        mismatches;

	// bits of word w whose index is below lim
	function automatic word_t usable_bits(logic [ADDR_W-1:0] w, logic [COUNT_W-1:0] lim);
		word_t m;
		for (int k = 0; k < WORD_BITS; k++) begin
			m[k] = (int'(w) * WORD_BITS + k) < int'(lim);
		end
		return m;
	endfunction

	function automatic response_t allocator_response(logic [CMD_W-1:0] cmd,
		logic [INDEX_W-1:0] idx);
		response_t          r;
		logic [COUNT_W-1:0] lim;
		logic [ADDR_W-1:0]  w;
		logic [BIT_W-1:0]   b;
		word_t              avail;
		logic               found;
		lim = (shadow_num_bits > MAX_COUNT) ? MAX_COUNT : shadow_num_bits;
		r = '0;
		found = 1'b0;
		b = '0;
		case (cmd) inside
			CMD_ALLOC: begin
				r.status = ST_FULL;
				if (shadow_used < lim) begin
					// cyclic scan from the word of the last grant
					for (int i = 0; i < NUM_WORDS; i++) begin
						w = shadow_last + ADDR_W'(i);
						avail = ~shadow_words[w] & usable_bits(w, lim);
						if (!found && avail != '0) begin
							for (int k = WORD_BITS - 1; k >= 0; k--) begin
								if (avail[k]) b = BIT_W'(k);
							end
							shadow_words[w][b] = 1'b1;
							shadow_last = w;
							shadow_used = shadow_used + 1'b1;
							r.alloc_index = {w, b};
							r.status = ST_OK;
							found = 1'b1;
						end
					end
				end
			end
			CMD_FREE, CMD_TEST: begin
				if (COUNT_W'(idx) >= lim) begin
					r.status = ST_RANGE;
				end else begin
					w = idx[INDEX_W-1:BIT_W];
					b = idx[BIT_W-1:0];
					if (cmd == CMD_FREE) begin
						// count drops only if the bit was really set
						if (shadow_words[w][b]) begin
							shadow_words[w][b] = 1'b0;
							if (shadow_used != '0) shadow_used = shadow_used - 1'b1;
						end
					end else begin
						r.is_set = shadow_words[w][b];
					end
				end
			end
			default: ;
		endcase
		r.used_count = shadow_used;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		response_t got;
		response_t want;
		logic      bad;
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) shadow_words[i] = '0;
			shadow_last = '0;
			shadow_used = '0;
			shadow_num_bits = MAX_COUNT;
			expected_responses.delete();
			mismatches = 0;
			failures = 0;
		end else begin
			// results first: a result never belongs to an item taken at the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				got.status      = m_axis_tuser;
				got.alloc_index = m_axis_tdata[INDEX_W-1:0];
				got.is_set      = m_axis_tdata[INDEX_W];
				got.used_count  = m_axis_tdata[INDEX_W+1 +: COUNT_W];
				if (expected_responses.size() == 0) begin
					failures++;
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: result with nothing pending: ",
							"status %0d index %0d set %0d count %0d"},
							$time, got.status, got.alloc_index, got.is_set,
							got.used_count);
				end else begin
					want = expected_responses.pop_front();
					bad = (got.status != want.status) || (got.alloc_index != want.alloc_index)
						|| (got.is_set != want.is_set) || (got.used_count != want.used_count)
						|| (m_axis_tdata[OUT_DATA_W-1:PAD_LO] != '0);
					if (bad) begin
						failures++;
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: mismatch exp status %0d index %0d set %0d ",
								"count %0d, got status %0d index %0d set %0d ",
								"count %0d pad %0h"},
								$time, want.status, want.alloc_index, want.is_set,
								want.used_count, got.status, got.alloc_index,
								got.is_set, got.used_count,
								m_axis_tdata[OUT_DATA_W-1:PAD_LO]);
					end
				end
			end
			if (cfg_valid && cfg_ready) shadow_num_bits = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				expected_responses.push_back(
					allocator_response(s_axis_tuser, s_axis_tdata[INDEX_W-1:0]));
		end
		outstanding = expected_responses.size();
	end

endmodule

// ===== test/tb_bitmap_index_allocator.sv =====
module tb_bitmap_index_allocator;
	timeunit 1ns;
	timeprecision 1ps;
	import bia_pkg::*;

	// cmd code the block must ignore
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	// cycles with no handshake on any channel before the run is abandoned;
	// slowest item is a full 32-word scan plus receiver stalls and sender gaps
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 78;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [COUNT_W-1:0]    cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [9:0] bit_index, rest zero
	logic [CMD_W-1:0]      s_axis_tuser = '0;   // [1:0] cmd
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // [9:0] alloc_index, [10] is_set,
	                                            // [21:11] used_count, rest zero
	logic [STATUS_W-1:0]   m_axis_tuser;        // [1:0] status

	int failures;
	int outstanding;
	int burst_left = 0;
	int quiet_cycles = 0;
	int ready_duty = 100;
	int duty_left = 0;
	logic [COUNT_W-1:0] num_bits_now = MAX_COUNT;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bitmap_index_allocator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// predicts every result and compares it, hands back the failure count
	bia_result_checker results_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.failures      (failures),
		.outstanding   (outstanding)
	);

	// receiver backpressure: stretches of fixed ready probability, from
	// always ready down to mostly stalled, each of random length
	always @(negedge clk) begin
		if (duty_left == 0) begin
			case ($urandom_range(0, 3))
				0: ready_duty = 100;
				1: ready_duty = 75;
				2: ready_duty = 40;
				default: ready_duty = 10;
			endcase
			duty_left = $urandom_range(16, 96);
		end
		duty_left--;
		m_axis_tready <= ($urandom_range(1, 100) <= ready_duty);
	end

	// watchdog: any handshake resets the quiet count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("bitmap_index_allocator verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one item on the input channel; items go out in bursts, and between
	// bursts valid may drop for a random gap (sometimes none at all)
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				s_axis_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = cmd;
		s_axis_tdata = IN_DATA_W'(idx);
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		burst_left--;
	endtask

	// num_bits only changes with the block idle: every result drained
	task automatic write_num_bits(input logic [COUNT_W-1:0] value);
		s_axis_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		num_bits_now = value;
	endtask

	// random item; frees and tests mostly land on low in-range indices so they
	// hit granted bits, the rest spread over the whole index field
	task automatic send_random(input int alloc_pct);
		int roll;
		int lim;
		int span;
		logic [CMD_W-1:0] cmd;
		logic [INDEX_W-1:0] idx;
		lim = (num_bits_now > MAX_COUNT) ? MAX_BITS : int'(num_bits_now);
		span = (lim > 256) ? 256 : lim;
		roll = $urandom_range(0, 99);
		if (roll < alloc_pct) cmd = CMD_ALLOC;
		else if (roll < alloc_pct + (100 - alloc_pct) * 6 / 10) cmd = CMD_FREE;
		else if (roll < 95) cmd = CMD_TEST;
		else cmd = CMD_UNKNOWN;
		if (cmd != CMD_ALLOC && span > 0 && $urandom_range(0, 9) < 8)
			idx = INDEX_W'($urandom_range(0, span - 1));
		else
			idx = INDEX_W'($urandom_range(0, MAX_BITS - 1));
		send_item(cmd, idx);
	endtask

	initial begin
		int nb;
		int alloc_pct;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset value of num_bits: empty map, lowest grants, free of a clear bit
		send_item(CMD_TEST, 10'd0);
		send_item(CMD_FREE, 10'd5);
		send_item(CMD_ALLOC, 10'd0);
		send_item(CMD_ALLOC, 10'd1023);
		send_item(CMD_ALLOC, 10'd512);
		send_item(CMD_TEST, 10'd1);
		send_item(CMD_TEST, 10'd1023);
		send_item(CMD_FREE, 10'd1);
		send_item(CMD_TEST, 10'd1);
		send_item(CMD_UNKNOWN, 10'd1023);
		send_item(CMD_FREE, 10'd1023);
		send_item(CMD_ALLOC, 10'd0);

		// zero: every allocate full, every index out of range
		write_num_bits(11'd0);
		send_item(CMD_ALLOC, 10'd0);
		send_item(CMD_FREE, 10'd0);
		send_item(CMD_TEST, 10'd0);

		// oversized value acts as the full store
		write_num_bits(11'd2047);
		send_item(CMD_ALLOC, 10'd0);
		send_item(CMD_TEST, 10'd1023);

		// one index while more are in use: full, range errors above it
		write_num_bits(11'd1);
		send_item(CMD_ALLOC, 10'd0);
		send_item(CMD_FREE, 10'd2);
		send_item(CMD_FREE, 10'd0);
		send_item(CMD_FREE, 10'd0);
		send_item(CMD_ALLOC, 10'd0);

		// limit just past one word boundary
		write_num_bits(11'd33);
		send_item(CMD_ALLOC, 10'd0);
		send_item(CMD_TEST, 10'd32);

		// random phases; small limits fill up, hit padding and wrap the scan
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: nb = 40;
				1: nb = 1;
				2: nb = 33;
				3: nb = 2047;
				4: nb = 64;
				5: nb = 0;
				6: nb = 1024;
				7: nb = 32;
				8: nb = 100;
				default: nb = $urandom_range(1, 200);
			endcase
			write_num_bits(COUNT_W'(nb));
			alloc_pct = $urandom_range(25, 70);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// front of each phase leans on allocation to reach the full state
				send_random((n < 25) ? 85 : alloc_pct);
			end
		end

		s_axis_tvalid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (40) @(negedge clk);

		if (failures == 0 && outstanding == 0) begin
			$display("bitmap_index_allocator verification clean");
		end else begin
			$display("bitmap_index_allocator verification failed");
		end
		$finish;
	end

endmodule
